>>> rtl/chebyshev_2d_series_eval_assert.svh
// Assertion macros shared by the Chebyshev series evaluator RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef CHEBYSHEV_2D_SERIES_EVAL_ASSERT_SVH
`define CHEBYSHEV_2D_SERIES_EVAL_ASSERT_SVH

// same-cycle implication
`define CHEB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cheb assertion failed");

// next-cycle implication
`define CHEB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cheb assertion failed");

`endif

>>> rtl/cheb_pkg.sv
// Shared types, constants and helper functions for the Chebyshev series evaluator.
// No dependencies; imported by the top level, cheb_front, cheb_back and the testbench.
`timescale 1ns / 1ps

package cheb_pkg;

  localparam int MAX_DEGREE  = 15;
  localparam int ORDER_W     = 4;
  localparam int ADDR_W      = 2 * ORDER_W;
  localparam int TABLE_DEPTH = 1 << ADDR_W;
  localparam int COEF_W      = 32;
  localparam int POINT_W     = 18;
  localparam int RESULT_W    = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [ORDER_W-1:0] MAX_ORDER     = ORDER_W'(MAX_DEGREE);
  localparam logic [ORDER_W-1:0] DEGREE_RESET  = 4'd10;
  localparam logic signed [POINT_W-1:0] Q_ONE  = 18'sd65536;
  localparam logic signed [POINT_W-1:0] Q_MONE = -18'sd65536;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_DEGREE_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEGREE_Y = 2'd1;

  typedef struct packed {
    logic                       command;
    logic [ORDER_W-1:0]         row;
    logic [ORDER_W-1:0]         col;
    logic signed [COEF_W-1:0]   value;
    logic signed [POINT_W-1:0]  x;
    logic signed [POINT_W-1:0]  y;
  } cheb_word_t;

  function automatic logic signed [POINT_W-1:0] clamp_point(logic signed [POINT_W-1:0] p);
    logic signed [POINT_W-1:0] r;
    r = p;
    if (p > Q_ONE) r = Q_ONE;
    else if (p < Q_MONE) r = Q_MONE;
    return r;
  endfunction

  function automatic logic [ORDER_W-1:0] eff_degree(logic [ORDER_W-1:0] d);
    return (d > MAX_ORDER) ? MAX_ORDER : d;
  endfunction

endpackage

>>> rtl/chebyshev_2d_series_eval.sv
// Top level of the two-dimensional Chebyshev series evaluator.
// Depends on cheb_pkg, cheb_front and cheb_back.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; a two-word queue sits in front of
// the evaluator, so busy only rises when two words wait. A load word writes one table
// entry and gives no result. An evaluate word gives exactly one result, a one-cycle
// pulse on result_valid that cannot be held off, so it must be captured when it shows.
// An evaluation uses the single shared multiplier and the one table read port, which
// reads one coefficient a cycle while a row is read; recurrence terms are computed
// only for a degree of 2 or more. The user must write the degree registers only while
// no evaluation is pending; the block itself does not enforce it.

module chebyshev_2d_series_eval (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [cheb_pkg::ORDER_W-1:0]         coef_row,
  input  logic [cheb_pkg::ORDER_W-1:0]         coef_col,
  input  logic signed [cheb_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [cheb_pkg::POINT_W-1:0]  point_x,
  input  logic signed [cheb_pkg::POINT_W-1:0]  point_y,
  output logic                                 result_valid,
  output logic signed [cheb_pkg::RESULT_W-1:0] series_value,
  output logic                                 saturated,
  input  logic                                 cfg_write,
  input  logic [cheb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cheb_pkg::ORDER_W-1:0]         cfg_data
);
  import cheb_pkg::*;

  logic [ORDER_W-1:0] degree_x;
  logic [ORDER_W-1:0] degree_y;
  cheb_word_t         head;
  logic               head_valid;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_x <= DEGREE_RESET;
      degree_y <= DEGREE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEGREE_X: degree_x <= cfg_data;
        REG_DEGREE_Y: degree_y <= cfg_data;
        default: ;
      endcase
    end
  end

  cheb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .coef_row   (coef_row),
    .coef_col   (coef_col),
    .coef_value (coef_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  cheb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .degree_x     (degree_x),
    .degree_y     (degree_y),
    .result_valid (result_valid),
    .series_value (series_value),
    .saturated    (saturated)
  );

endmodule

>>> rtl/cheb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cheb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cheb_front.sv
// Front end: accepts command words, clamps coordinates and queues them.
// Depends on cheb_pkg.
`timescale 1ns / 1ps

module cheb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command,
  input  logic [cheb_pkg::ORDER_W-1:0]       coef_row,
  input  logic [cheb_pkg::ORDER_W-1:0]       coef_col,
  input  logic signed [cheb_pkg::COEF_W-1:0] coef_value,
  input  logic signed [cheb_pkg::POINT_W-1:0] point_x,
  input  logic signed [cheb_pkg::POINT_W-1:0] point_y,
  output cheb_pkg::cheb_word_t               head,
  output logic                               head_valid,
  input  logic                               pop
);
  import cheb_pkg::*;

  cheb_word_t             queue [QUEUE_DEPTH];
  cheb_word_t             word_in;
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;

  assign busy       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push       = start && !busy;
  assign head       = queue[rd_ptr];

  always_comb begin
    word_in.command = command;
    word_in.row     = coef_row;
    word_in.col     = coef_col;
    word_in.value   = coef_value;
    word_in.x       = clamp_point(point_x);
    word_in.y       = clamp_point(point_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= word_in;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/cheb_back.sv
// Back end: coefficient table, Chebyshev recurrences and the shared multiply-accumulate.
// Depends on cheb_pkg, cheb_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "chebyshev_2d_series_eval_assert.svh"

module cheb_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cheb_pkg::cheb_word_t                 head,
  input  logic                                 head_valid,
  output logic                                 pop,
  input  logic [cheb_pkg::ORDER_W-1:0]         degree_x,
  input  logic [cheb_pkg::ORDER_W-1:0]         degree_y,
  output logic                                 result_valid,
  output logic signed [cheb_pkg::RESULT_W-1:0] series_value,
  output logic                                 saturated
);
  import cheb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_REC_MUL, S_REC_ADD, S_ROW, S_DRAIN, S_OUT_MUL, S_OUT_ACC, S_FIN
  } state_t;

  localparam logic signed [48:0] SAT_HI = 49'sd140737488355327;
  localparam logic signed [48:0] SAT_LO = -49'sd140737488355328;

  state_t                    state;
  logic                      phase_x;
  logic signed [POINT_W-1:0] pt_x, pt_y;
  logic [ORDER_W-1:0]        dx, dy, k, m, n, n_d1;
  logic                      v1, v2;
  logic signed [POINT_W-1:0] ty [MAX_DEGREE+1];
  logic signed [POINT_W-1:0] ty_prev, ty_cur, tx_prev, tx_cur;
  logic signed [54:0]        prod;
  logic signed [52:0]        am;
  logic signed [57:0]        acc;

  logic                      ram_we;
  logic [COEF_W-1:0]         rd_data;
  logic signed [36:0]        mul_a;
  logic signed [POINT_W-1:0] mul_b;

  logic signed [37:0]        rec_sum;
  logic signed [21:0]        rec_diff;
  logic signed [POINT_W-1:0] rec_prev, rec_new;
  logic signed [52:0]        am_sum;
  logic signed [57:0]        acc_sum;
  logic signed [48:0]        z_ext;

  assign pop    = (state == S_IDLE) && head_valid;
  assign ram_we = pop && (head.command == CMD_LOAD);

  cheb_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({head.row, head.col}),
    .wdata (head.value),
    .raddr ({m, n}),
    .rdata (rd_data)
  );

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_REC_MUL: begin
        mul_a = phase_x ? 37'(pt_x) : 37'(pt_y);
        mul_b = phase_x ? tx_cur : ty_cur;
      end
      S_OUT_MUL: begin
        mul_a = am_sum[52:16];
        mul_b = tx_cur;
      end
      default: begin
        mul_a = 37'($signed(rd_data));
        mul_b = ty[n_d1];
      end
    endcase
  end

  // T_k = clamp(round(2*t*T_{k-1}) - T_{k-2}); round-half-up is add then arithmetic shift
  always_comb begin
    rec_prev = phase_x ? tx_prev : ty_prev;
    rec_sum  = $signed({prod[36:0], 1'b0}) + 38'sd32768;
    rec_diff = rec_sum[37:16] - 22'(rec_prev);
    if (rec_diff > 22'(Q_ONE)) rec_new = Q_ONE;
    else if (rec_diff < 22'(Q_MONE)) rec_new = Q_MONE;
    else rec_new = rec_diff[POINT_W-1:0];
    am_sum  = am + 53'sd32768;
    acc_sum = acc + 58'sd32768;
    z_ext   = 49'($signed(acc_sum[57:16]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      prod         <= mul_a * mul_b;
      v1           <= (state == S_ROW);
      v2           <= v1;
      n_d1         <= n;
      result_valid <= (state == S_FIN);
      if (v2) begin
        am <= am + prod[52:0];
      end
      case (state)
        S_IDLE: begin
          if (pop && head.command == CMD_EVAL) begin
            pt_x    <= head.x;
            pt_y    <= head.y;
            dx      <= eff_degree(degree_x);
            dy      <= eff_degree(degree_y);
            ty[0]   <= Q_ONE;
            ty[1]   <= head.y;
            ty_prev <= Q_ONE;
            ty_cur  <= head.y;
            tx_prev <= Q_ONE;
            tx_cur  <= Q_ONE;
            k       <= 4'd2;
            m       <= '0;
            n       <= '0;
            phase_x <= 1'b0;
            am      <= '0;
            acc     <= '0;
            state   <= (eff_degree(degree_y) >= 4'd2) ? S_REC_MUL : S_ROW;
          end
        end
        S_REC_MUL: begin
          state <= S_REC_ADD;
        end
        S_REC_ADD: begin
          if (phase_x) begin
            tx_prev <= tx_cur;
            tx_cur  <= rec_new;
            state   <= S_ROW;
          end else begin
            ty[k]   <= rec_new;
            ty_prev <= ty_cur;
            ty_cur  <= rec_new;
            k       <= k + 1'b1;
            state   <= (k == dy) ? S_ROW : S_REC_MUL;
          end
        end
        S_ROW: begin
          n <= n + 1'b1;
          if (n == dy) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_OUT_MUL;
          end
        end
        S_OUT_MUL: begin
          state <= S_OUT_ACC;
        end
        S_OUT_ACC: begin
          acc <= acc + 58'(prod);
          am  <= '0;
          n   <= '0;
          if (m == dx) begin
            state <= S_FIN;
          end else begin
            m <= m + 1'b1;
            if (m == '0) begin
              tx_prev <= tx_cur;
              tx_cur  <= pt_x;
              state   <= S_ROW;
            end else begin
              phase_x <= 1'b1;
              state   <= S_REC_MUL;
            end
          end
        end
        S_FIN: begin
          if (z_ext > SAT_HI) begin
            series_value <= SAT_HI[RESULT_W-1:0];
            saturated    <= 1'b1;
          end else if (z_ext < SAT_LO) begin
            series_value <= SAT_LO[RESULT_W-1:0];
            saturated    <= 1'b1;
          end else begin
            series_value <= z_ext[RESULT_W-1:0];
            saturated    <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHEB_ASSERT_NXT(a_result_pulse, clk, rst, result_valid, !result_valid)
  `CHEB_ASSERT_IMP(a_result_from_fin, clk, rst, result_valid, $past(state == S_FIN))
  `CHEB_ASSERT_IMP(a_row_drained, clk, rst, state == S_OUT_MUL, !v1 && !v2)
  `CHEB_ASSERT_IMP(a_load_quiet, clk, rst, ram_we, !v1 && !v2)

endmodule

>>> tb/tb_chebyshev_2d_series_eval.sv
// Self-checking testbench for chebyshev_2d_series_eval: directed table, then random
// load/evaluate traffic over several degree settings, checked against a built-in predictor.
// Depends on cheb_pkg and the chebyshev_2d_series_eval RTL.
`timescale 1ns / 1ps

module tb_chebyshev_2d_series_eval;
  import cheb_pkg::*;

  localparam longint Q1              = 65536;
  localparam longint SUM_MAX         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN         = -SUM_MAX - 1;
  localparam int     SETTLE_CYCLES   = 32;
  localparam int     TAIL_CYCLES     = 600;
  localparam int     NUM_PHASES      = 8;
  localparam int     ITEMS_PER_PHASE = 47;
  localparam int     LIMIT_NS        = 3_000_000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic                       sat;
  } series_t;

  typedef enum logic [1:0] {STEP_LOAD, STEP_EVAL, STEP_DEGREES} step_kind_t;

  typedef struct {
    step_kind_t                 kind;
    logic [ORDER_W-1:0]         a;
    logic [ORDER_W-1:0]         b;
    logic signed [COEF_W-1:0]   value;
    logic signed [POINT_W-1:0]  x;
    logic signed [POINT_W-1:0]  y;
    bit                         typed;
    logic signed [RESULT_W-1:0] sum;
  } dir_step_t;

  logic                          clk;
  logic                          rst        = 1'b1;
  logic                          start      = 1'b0;
  logic                          busy;
  logic                          command    = CMD_LOAD;
  logic [ORDER_W-1:0]            coef_row   = '0;
  logic [ORDER_W-1:0]            coef_col   = '0;
  logic signed [COEF_W-1:0]      coef_value = '0;
  logic signed [POINT_W-1:0]     point_x    = '0;
  logic signed [POINT_W-1:0]     point_y    = '0;
  logic                          result_valid;
  logic signed [RESULT_W-1:0]    series_value;
  logic                          saturated;
  logic                          cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index  = '0;
  logic [ORDER_W-1:0]            cfg_data   = '0;

  logic signed [COEF_W-1:0] coef_shadow [TABLE_DEPTH];
  logic [ORDER_W-1:0]       deg_x_shadow = DEGREE_RESET;
  logic [ORDER_W-1:0]       deg_y_shadow = DEGREE_RESET;
  series_t                  pending_sums [$];
  dir_step_t                directed [$];
  int                       mismatches = 0;

  chebyshev_2d_series_eval u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .coef_row     (coef_row),
    .coef_col     (coef_col),
    .coef_value   (coef_value),
    .point_x      (point_x),
    .point_y      (point_y),
    .result_valid (result_valid),
    .series_value (series_value),
    .saturated    (saturated),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // divide by 2^16, nearest, ties up
  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_q1(longint v);
    if (v > Q1) return Q1;
    if (v < -Q1) return -Q1;
    return v;
  endfunction

  function automatic longint cheb_term(longint p, int k);
    longint prev, cur, nxt;
    int     i;
    if (k == 0) return Q1;
    prev = Q1;
    cur  = p;
    for (i = 2; i <= k; i++) begin
      nxt  = clamp_q1(round_q16(2 * p * cur) - prev);
      prev = cur;
      cur  = nxt;
    end
    return cur;
  endfunction

  function automatic series_t series_at(logic signed [POINT_W-1:0] px,
                                        logic signed [POINT_W-1:0] py);
    longint  x, y, acc, row_sum, z;
    int      m, n;
    series_t r;
    x   = clamp_q1(longint'(px));
    y   = clamp_q1(longint'(py));
    acc = 0;
    for (m = 0; m <= int'(deg_x_shadow); m++) begin
      row_sum = 0;
      for (n = 0; n <= int'(deg_y_shadow); n++)
        row_sum += longint'(coef_shadow[m * 16 + n]) * cheb_term(y, n);
      acc += round_q16(row_sum) * cheb_term(x, m);
    end
    z     = round_q16(acc);
    r.sat = 1'b0;
    if (z > SUM_MAX) begin
      z     = SUM_MAX;
      r.sat = 1'b1;
    end else if (z < SUM_MIN) begin
      z     = SUM_MIN;
      r.sat = 1'b1;
    end
    r.value = z[RESULT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POINT_W-1:0] rand_point();
    case ($urandom_range(0, 9))
      0:       return POINT_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return Q_ONE;
          1:       return Q_MONE;
          2:       return 18'sh1FFFF;
          3:       return 18'sh20000;
          default: return '0;
        endcase
      end
      default: return POINT_W'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic cheb_word_t make_word(logic cmd);
    cheb_word_t w;
    w.command = cmd;
    w.row     = ORDER_W'($urandom);
    w.col     = ORDER_W'($urandom);
    case ($urandom_range(0, 7))
      0:       w.value = 32'sh7FFF_FFFF;
      1:       w.value = 32'sh8000_0000;
      2:       w.value = COEF_W'(int'($urandom_range(0, 131072)) - 65536);
      default: w.value = COEF_W'($urandom);
    endcase
    w.x = rand_point();
    w.y = rand_point();
    return w;
  endfunction

  function automatic dir_step_t step(step_kind_t kind, int a, int b, int value,
                                     int x, int y, bit typed, longint sum);
    dir_step_t s;
    s.kind  = kind;
    s.a     = a[ORDER_W-1:0];
    s.b     = b[ORDER_W-1:0];
    s.value = value;
    s.x     = x[POINT_W-1:0];
    s.y     = y[POINT_W-1:0];
    s.typed = typed;
    s.sum   = sum[RESULT_W-1:0];
    return s;
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_item(input cheb_word_t w, input bit typed,
                           input logic signed [RESULT_W-1:0] sum);
    series_t e;
    start      <= 1'b1;
    command    <= w.command;
    coef_row   <= w.row;
    coef_col   <= w.col;
    coef_value <= w.value;
    point_x    <= w.x;
    point_y    <= w.y;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.command == CMD_EVAL) begin
      if (typed) begin
        e.value = sum;
        e.sat   = 1'b0;
      end else begin
        e = series_at(w.x, w.y);
      end
      pending_sums.push_back(e);
    end else begin
      coef_shadow[{w.row, w.col}] = w.value;
    end
  endtask

  task automatic idle_gap(input bit no_wait);
    int gap;
    gap = no_wait ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait out every pending evaluation, plus slack for trailing loads
  task automatic settle();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_degrees(input logic [ORDER_W-1:0] dx, input logic [ORDER_W-1:0] dy);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= ORDER_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_DEGREE_X;
    cfg_data  <= dx;
    @(posedge clk);
    cfg_index <= REG_DEGREE_Y;
    cfg_data  <= dy;
    @(posedge clk);
    cfg_write    <= 1'b0;
    deg_x_shadow = dx;
    deg_y_shadow = dy;
  endtask

  always @(posedge clk) begin
    series_t e;
    if (!rst && result_valid) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: %0d sat %0b", series_value, saturated);
      end else begin
        e = pending_sums.pop_front();
        if (series_value !== e.value || saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d sat %0b, got %0d sat %0b",
                     e.value, e.sat, series_value, saturated);
        end
      end
    end
  end

  initial begin
    int         i, p, k;
    bit         burst;
    cheb_word_t w;
    dir_step_t  s;

    // at reset degrees
    directed.push_back(step(STEP_EVAL,  0,  0,  0,       0,       0, 0, 0));
    directed.push_back(step(STEP_EVAL, 15, 15, -1,   65536,   65536, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,  -65536,  -65536, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,  131071, -131072, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0, -131072,  131071, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,   65537,  -65537, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,   32768,      -1, 0, 0));
    // degree zero on both axes: result is A[0][0]
    directed.push_back(step(STEP_DEGREES, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(step(STEP_LOAD,  0,  0, 2147483647, 131071, -131072, 0, 0));
    directed.push_back(step(STEP_EVAL, 15, 15, -1,   12345,  -54321, 1, 2147483647));
    directed.push_back(step(STEP_LOAD,  0,  0, -2147483647 - 1, 0, 0, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,  131071,  131071, 1, -2147483647 - 1));
    directed.push_back(step(STEP_LOAD, 15, 15, -1,       0,       0, 0, 0));
    directed.push_back(step(STEP_LOAD,  0,  0,  0,       0,       0, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0, -131072,       0, 1, 0));
    directed.push_back(step(STEP_LOAD,  0,  0,  1,       0,       0, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,   65536,  -65536, 1, 1));
    // full degree
    directed.push_back(step(STEP_DEGREES, 15, 15, 0, 0, 0, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,   65536,   65536, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,  -65536,   65536, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,       0,       0, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,       1,      -1, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,   65535,  -65535, 0, 0));
    directed.push_back(step(STEP_DEGREES, 0, 15, 0, 0, 0, 0, 0));
    directed.push_back(step(STEP_EVAL,  0,  0,  0,   40000,  -20000, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // write every table entry before anything reads it
    for (i = 0; i < TABLE_DEPTH; i++) begin
      w     = make_word(CMD_LOAD);
      w.row = i[7:4];
      w.col = i[3:0];
      send_item(w, 1'b0, '0);
      idle_gap(i < 64);
    end

    foreach (directed[j]) begin
      s = directed[j];
      if (s.kind == STEP_DEGREES) begin
        set_degrees(s.a, s.b);
      end else begin
        w         = make_word(s.kind == STEP_EVAL ? CMD_EVAL : CMD_LOAD);
        w.row     = s.a;
        w.col     = s.b;
        w.value   = s.value;
        w.x       = s.x;
        w.y       = s.y;
        send_item(w, s.typed, s.sum);
        idle_gap(1'b0);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       set_degrees(4'd15, 4'd0);
        1:       set_degrees(4'd1, 4'd1);
        2:       set_degrees(4'd15, 4'd15);
        3:       set_degrees(4'd3, 4'd7);
        4:       set_degrees(4'd0, 4'd0);
        5:       set_degrees(4'd10, 4'd10);
        default: set_degrees(ORDER_W'($urandom), ORDER_W'($urandom));
      endcase
      burst = (p % 3 == 2);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        w = make_word(($urandom_range(0, 99) < 60) ? CMD_EVAL : CMD_LOAD);
        send_item(w, 1'b0, '0);
        if ($urandom_range(0, 39) == 0) settle();
        else idle_gap(burst);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_sums.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
